/* rtl/wfcu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfcu_pkg: shared types and constants for the weather frame checker
// Frame layout constants, status codes and the record passed front to back.
// ----------------------------------------------------------------------------
package wfcu_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_status;

    // Status codes
    localparam t_status STATUS_VALID    = 2'd0;
    localparam t_status STATUS_PREAMBLE = 2'd1;
    localparam t_status STATUS_CHECKSUM = 2'd2;

    // Frame layout
    localparam int          FRAME_LEN   = 12;
    localparam int          CNT_W       = 4;
    localparam int          FIELD_FIRST = 3;    // first captured byte
    localparam int          FIELD_NUM   = 8;    // bytes 3..10
    localparam int          XOR_LAST    = 9;    // last byte folded into the XORs
    localparam int          PREAMBLE_N  = 3;
    localparam t_byte       PREAMBLE_0  = 8'h55;
    localparam t_byte       PREAMBLE_1  = 8'h5A;
    localparam t_byte       PREAMBLE_2  = 8'h67;
    localparam logic [6:0]  CHECK_KEY   = 7'h18;

    // Unpack scale factors
    localparam logic [6:0]  RAIN_FACTOR = 7'd79;
    localparam logic [5:0]  DIR_FACTOR  = 6'd45;

    // Record queue between front and back (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One finished frame: status plus the raw field bytes 3..9
    typedef struct packed {
        t_status status;
        t_byte   b3;
        t_byte   b4;
        t_byte   b5;
        t_byte   b6;
        t_byte   b7;
        t_byte   b8;
        t_byte   b9;
    } t_frame;

    // Expected raw preamble byte at position idx (0..2)
    function automatic t_byte preamble_byte(input logic [1:0] idx);
        t_byte v;
        unique case (idx)
            2'd0:    v = PREAMBLE_0;
            2'd1:    v = PREAMBLE_1;
            default: v = PREAMBLE_2;
        endcase
        return v;
    endfunction

    // Check value: E ^ O ^ mix of shifted E selected by the key bits
    function automatic t_byte check_value(input t_byte e, input t_byte o);
        t_byte mix;
        mix = '0;
        for (int j = 0; j < 7; j++) begin
            if (CHECK_KEY[j]) begin
                mix = mix ^ t_byte'(e << (j + 1));
            end
        end
        return e ^ o ^ mix;
    endfunction

endpackage
`default_nettype wire

/* rtl/wfcu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfcu_front: byte intake and frame classification
// Counts bytes, checks the preamble, keeps the even/odd XORs, captures the
// field bytes and emits one frame record after byte 11.
// ----------------------------------------------------------------------------
module wfcu_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_frame_start,
    input  wire                   i_push,
    output logic                  o_full,
    input  wire                   i_q_full,
    output logic                  o_rec_push,
    output wfcu_pkg::t_frame      o_rec
);
    import wfcu_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    t_byte            r_even, n_even;
    t_byte            r_odd, n_odd;
    logic             r_hdr_ok, n_hdr_ok;
    t_byte            r_fb [FIELD_NUM];

    logic [CNT_W-1:0] s_cnt;
    t_byte            s_even, s_odd, s_inv;
    logic             s_hdr_ok, s_accept, s_last;

    assign o_full   = i_q_full;
    assign s_accept = i_push && !i_q_full;
    assign s_inv    = ~i_data_byte;

    // Frame start restarts the count and clears the running state first
    always_comb begin
        s_cnt    = i_frame_start ? '0 : r_count;
        s_even   = i_frame_start ? '0 : r_even;
        s_odd    = i_frame_start ? '0 : r_odd;
        s_hdr_ok = i_frame_start ? 1'b1 : r_hdr_ok;
    end

    assign s_last = (s_cnt == CNT_W'(FRAME_LEN - 1));

    // Next state of the running frame state
    always_comb begin
        n_count  = r_count;
        n_even   = r_even;
        n_odd    = r_odd;
        n_hdr_ok = r_hdr_ok;
        if (s_accept) begin
            n_count  = s_cnt;
            n_even   = s_even;
            n_odd    = s_odd;
            n_hdr_ok = s_hdr_ok;
            if (s_cnt < CNT_W'(FRAME_LEN)) begin
                n_count = s_cnt + 1'b1;
                if (s_cnt < CNT_W'(PREAMBLE_N) &&
                    i_data_byte != preamble_byte(s_cnt[1:0])) begin
                    n_hdr_ok = 1'b0;
                end
                if (s_cnt <= CNT_W'(XOR_LAST)) begin
                    if (s_cnt[0]) begin
                        n_odd = s_odd ^ s_inv;
                    end else begin
                        n_even = s_even ^ s_inv;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_even   <= '0;
            r_odd    <= '0;
            r_hdr_ok <= 1'b1;
        end else begin
            r_count  <= n_count;
            r_even   <= n_even;
            r_odd    <= n_odd;
            r_hdr_ok <= n_hdr_ok;
        end
    end

    // Field byte capture, one slot per byte position
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FIELD_NUM; k++) begin
            if (s_accept && s_cnt == CNT_W'(k + FIELD_FIRST)) begin
                r_fb[k] <= s_inv;
            end
        end
    end

    // Record out on the last byte; byte 10 already sits in the last slot
    always_comb begin
        o_rec_push = s_accept && s_last;
        if (!s_hdr_ok) begin
            o_rec.status = STATUS_PREAMBLE;
        end else if (check_value(s_even, s_odd) != r_fb[FIELD_NUM-1]) begin
            o_rec.status = STATUS_CHECKSUM;
        end else begin
            o_rec.status = STATUS_VALID;
        end
        o_rec.b3 = r_fb[0];
        o_rec.b4 = r_fb[1];
        o_rec.b5 = r_fb[2];
        o_rec.b6 = r_fb[3];
        o_rec.b7 = r_fb[4];
        o_rec.b8 = r_fb[5];
        o_rec.b9 = r_fb[6];
    end

endmodule
`default_nettype wire

/* rtl/wfcu_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfcu_queue: short frame record queue
// Decouples the byte intake from the unpack stage.
// ----------------------------------------------------------------------------
module wfcu_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wfcu_pkg::t_frame      i_rec,
    output logic                  o_full,
    input  wire                   i_pop,
    output logic                  o_empty,
    output wfcu_pkg::t_frame      o_rec
);
    import wfcu_pkg::*;

    t_frame             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               s_do_push, s_do_pop;

    assign o_full    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign s_do_push = i_push && !o_full;
    assign s_do_pop  = i_pop && !o_empty;
    assign o_rec     = r_mem[r_rd_ptr];

    // Pointers and fill count; pointers wrap since depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (s_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (s_do_push && !s_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (s_do_pop && !s_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (s_do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule
`default_nettype wire

/* rtl/wfcu_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfcu_back: field unpack and result register
// Scales the raw field bytes into engineering units and holds the result
// until it is popped.
// ----------------------------------------------------------------------------
module wfcu_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_q_empty,
    input  wfcu_pkg::t_frame      i_rec,
    output logic                  o_q_pop,
    input  wire                   i_pop,
    output logic                  o_empty,
    output logic [1:0]            o_status,
    output logic [7:0]            o_station_id,
    output logic                  o_batt_good,
    output logic signed [11:0]    o_temperature_tenths,
    output logic [7:0]            o_humidity_pct,
    output logic [18:0]           o_rain_hundredths_mm,
    output logic [7:0]            o_wind_speed_kmh,
    output logic [8:0]            o_wind_heading
);
    import wfcu_pkg::*;

    logic               r_valid;
    logic               s_take, s_ok;
    logic [11:0]        s_rain_cnt;
    logic [18:0]        s_rain;
    logic [9:0]         s_dir_x2;

    t_status            r_status;
    t_byte              r_id, r_hum, r_wind;
    logic               r_batt;
    logic signed [11:0] r_temp;
    logic [18:0]        r_rain;
    logic [8:0]         r_dir;

    // Load the result register when it is free or being drained
    assign s_take  = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = s_take;
    assign o_empty = !r_valid;
    assign s_ok    = (i_rec.status == STATUS_VALID);

    // Unit scaling
    assign s_rain_cnt = {i_rec.b7, i_rec.b8[7:4]};
    assign s_rain     = 19'(s_rain_cnt * RAIN_FACTOR);
    assign s_dir_x2   = 10'(i_rec.b9[3:0] * DIR_FACTOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload; failed frames carry zero fields
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_status <= i_rec.status;
            r_id     <= s_ok ? i_rec.b3 : '0;
            r_batt   <= s_ok && !i_rec.b4[7];
            r_temp   <= s_ok ? $signed({i_rec.b4[3:0], i_rec.b5}) : '0;
            r_hum    <= s_ok ? i_rec.b6 : '0;
            r_rain   <= s_ok ? s_rain : '0;
            r_wind   <= s_ok ? {i_rec.b8[3:0], i_rec.b9[7:4]} : '0;
            r_dir    <= s_ok ? s_dir_x2[9:1] : '0;
        end
    end

    assign o_status             = r_status;
    assign o_station_id         = r_id;
    assign o_batt_good          = r_batt;
    assign o_temperature_tenths = r_temp;
    assign o_humidity_pct       = r_hum;
    assign o_rain_hundredths_mm = r_rain;
    assign o_wind_speed_kmh     = r_wind;
    assign o_wind_heading       = r_dir;

endmodule
`default_nettype wire

/* rtl/weather_frame_check_and_unpack.sv */
`default_nettype none
// Result path: with the result register free, the record for byte 11 passes
//   through the record queue write, then the result register, to the outputs.
// Throughput: one byte per cycle; the intake stalls only while the two-entry
//   record queue is full.
// Reset: synchronous active low; byte count, XORs and queue are cleared,
//   header flag set, no result pending.
// ----------------------------------------------------------------------------
// weather_frame_check_and_unpack: sensor frame checker and unpacker
// Intake front end, record queue and unpack back end with a result register.
// ----------------------------------------------------------------------------
module weather_frame_check_and_unpack (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_frame_start,
    input  wire                   push,
    output logic                  full,
    output logic                  empty,
    input  wire                   pop,
    output logic [1:0]            o_status,
    output logic [7:0]            o_station_id,
    output logic                  o_batt_good,
    output logic signed [11:0]    o_temperature_tenths,
    output logic [7:0]            o_humidity_pct,
    output logic [18:0]           o_rain_hundredths_mm,
    output logic [7:0]            o_wind_speed_kmh,
    output logic [8:0]            o_wind_heading
);
    import wfcu_pkg::*;

    t_frame s_front_rec, s_back_rec;
    logic   s_rec_push, s_q_full, s_q_empty, s_q_pop;

    // Byte intake and classification
    wfcu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_push        (push),
        .o_full        (full),
        .i_q_full      (s_q_full),
        .o_rec_push    (s_rec_push),
        .o_rec         (s_front_rec)
    );

    // Frame record queue
    wfcu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_rec_push),
        .i_rec   (s_front_rec),
        .o_full  (s_q_full),
        .i_pop   (s_q_pop),
        .o_empty (s_q_empty),
        .o_rec   (s_back_rec)
    );

    // Unpack and result register
    wfcu_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_empty            (s_q_empty),
        .i_rec                (s_back_rec),
        .o_q_pop              (s_q_pop),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_status             (o_status),
        .o_station_id         (o_station_id),
        .o_batt_good          (o_batt_good),
        .o_temperature_tenths (o_temperature_tenths),
        .o_humidity_pct       (o_humidity_pct),
        .o_rain_hundredths_mm (o_rain_hundredths_mm),
        .o_wind_speed_kmh     (o_wind_speed_kmh),
        .o_wind_heading       (o_wind_heading)
    );

endmodule
`default_nettype wire

/* dv/weather_frame_check_and_unpack_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weather_frame_check_and_unpack_tb: self-checking bench for the frame checker
// Pushes inverted sensor frames through the byte queue: valid, bad preamble,
// bad checksum, truncated, padded and unflagged frames. A local model predicts
// each unpacked record, and the monitor compares it field by field at pop time.
// ----------------------------------------------------------------------------
module weather_frame_check_and_unpack_tb;
    import wfcu_pkg::*;

    // One byte transaction on the push side
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_byte_item;

    // One unpacked weather record
    typedef struct packed {
        t_status     status;
        logic [7:0]  station_id;
        logic        batt_good;
        logic [11:0] temperature;
        logic [7:0]  humidity;
        logic [18:0] rain;
        logic [7:0]  wind_speed;
        logic [8:0]  wind_heading;
    } t_weather_rec;

    localparam logic [7:0] SYNC_RAW [PREAMBLE_N] = '{PREAMBLE_0, PREAMBLE_1, PREAMBLE_2};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_frame_start = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_status;
    logic [7:0]  o_station_id;
    logic        o_batt_good;
    logic signed [11:0] o_temperature_tenths;
    logic [7:0]  o_humidity_pct;
    logic [18:0] o_rain_hundredths_mm;
    logic [7:0]  o_wind_speed_kmh;
    logic [8:0]  o_wind_heading;

    weather_frame_check_and_unpack uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_data_byte          (i_data_byte),
        .i_frame_start        (i_frame_start),
        .push                 (push),
        .full                 (full),
        .empty                (empty),
        .pop                  (pop),
        .o_status             (o_status),
        .o_station_id         (o_station_id),
        .o_batt_good          (o_batt_good),
        .o_temperature_tenths (o_temperature_tenths),
        .o_humidity_pct       (o_humidity_pct),
        .o_rain_hundredths_mm (o_rain_hundredths_mm),
        .o_wind_speed_kmh     (o_wind_speed_kmh),
        .o_wind_heading       (o_wind_heading)
    );

    // Stimulus and expected records
    t_byte_item   byte_q [$];
    t_weather_rec record_q [$];

    // Frame tracking state of the local model
    logic [3:0]  frame_pos = '0;
    logic [7:0]  even_acc = '0;
    logic [7:0]  odd_acc = '0;
    logic        preamble_good = 1'b1;
    logic [7:0]  field_b [FIELD_FIRST:FIELD_FIRST+FIELD_NUM-1];

    // Run control and statistics
    logic byte_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   rx_hold = 0;
    int   items_sent = 0;
    int   records_checked = 0;
    int   status_seen [3] = '{0, 0, 0};
    int   stall_cycles = 0;
    int   fail_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check byte: E ^ O ^ (E << 4) ^ (E << 5), kept to 8 bits
    function automatic logic [7:0] checksum_of(input logic [7:0] e, input logic [7:0] o);
        logic [7:0] r;
        r = e ^ o ^ 8'(e << 4) ^ 8'(e << 5);
        return r;
    endfunction

    // Model one accepted byte; queue a record when a frame completes
    task automatic predict_byte(input logic [7:0] raw, input logic start);
        logic [7:0]   inv;
        logic [11:0]  rain_cnt;
        logic [9:0]   dir_x;
        t_weather_rec rec;
        inv = ~raw;
        if (start) begin
            frame_pos     = '0;
            even_acc      = '0;
            odd_acc       = '0;
            preamble_good = 1'b1;
        end
        if (frame_pos < FRAME_LEN) begin
            if (frame_pos < PREAMBLE_N && raw != SYNC_RAW[frame_pos[1:0]]) begin
                preamble_good = 1'b0;
            end
            if (frame_pos <= XOR_LAST) begin
                if (frame_pos[0]) begin
                    odd_acc = odd_acc ^ inv;
                end else begin
                    even_acc = even_acc ^ inv;
                end
            end
            if (frame_pos >= FIELD_FIRST && frame_pos < FIELD_FIRST + FIELD_NUM) begin
                field_b[frame_pos] = inv;
            end
            frame_pos = frame_pos + 4'd1;
            if (frame_pos == FRAME_LEN) begin
                rec = '0;
                if (!preamble_good) begin
                    rec.status = STATUS_PREAMBLE;
                end else if (checksum_of(even_acc, odd_acc) != field_b[10]) begin
                    rec.status = STATUS_CHECKSUM;
                end else begin
                    rec.status       = STATUS_VALID;
                    rec.station_id   = field_b[3];
                    rec.batt_good    = ~field_b[4][7];
                    rec.temperature  = {field_b[4][3:0], field_b[5]};
                    rec.humidity     = field_b[6];
                    rain_cnt         = {field_b[7], field_b[8][7:4]};
                    rec.rain         = 19'(rain_cnt) * 19'(RAIN_FACTOR);
                    rec.wind_speed   = {field_b[8][3:0], field_b[9][7:4]};
                    dir_x            = 10'(field_b[9][3:0]) * 10'(DIR_FACTOR);
                    rec.wind_heading = dir_x[9:1];
                end
                record_q.push_back(rec);
            end
        end
    endtask

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare the popped record with the oldest expected one
    task automatic check_record();
        t_weather_rec want;
        if (record_q.size() == 0) begin
            $error("record popped with none expected: status %0d", o_status);
            fail_count++;
        end else begin
            want = record_q.pop_front();
            compare_field("status", int'(want.status), int'(o_status));
            compare_field("station_id", int'(want.station_id), int'(o_station_id));
            compare_field("batt_good", int'(want.batt_good), int'(o_batt_good));
            compare_field("temperature_tenths", int'($signed(want.temperature)),
                          int'(o_temperature_tenths));
            compare_field("humidity_pct", int'(want.humidity), int'(o_humidity_pct));
            compare_field("rain_hundredths_mm", int'(want.rain), int'(o_rain_hundredths_mm));
            compare_field("wind_speed_kmh", int'(want.wind_speed), int'(o_wind_speed_kmh));
            compare_field("wind_heading", int'(want.wind_heading), int'(o_wind_heading));
            records_checked++;
            if (want.status <= STATUS_CHECKSUM) begin
                status_seen[want.status]++;
            end
        end
    endtask

    // Monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= push && !full;
            if (push && !full) begin
                predict_byte(i_data_byte, i_frame_start);
            end
            if (push && full) begin
                stall_cycles++;
            end
            if (pop && !empty) begin
                check_record();
            end
        end
    end

    // Driver: retire the accepted byte, then offer the next one and pick pop
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (byte_taken) begin
                void'(byte_q.pop_front());
            end
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                push          <= 1'b1;
                i_data_byte   <= byte_q[0].data;
                i_frame_start <= byte_q[0].start;
            end else begin
                push          <= 1'b0;
                i_data_byte   <= 8'($urandom);
                i_frame_start <= 1'($urandom);
            end
            pop <= (rx_hold == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted down in cycles
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Build one frame from inverted field bytes 3..9 and queue its raw bytes
    task automatic queue_frame(input logic [55:0] fields, input bit first_start,
                               input bit pre_ok, input bit sum_ok, input int len);
        logic [7:0] inv [FRAME_LEN];
        logic [7:0] even_x;
        logic [7:0] odd_x;
        int         bad;
        for (int k = 0; k < PREAMBLE_N; k++) begin
            inv[k] = ~SYNC_RAW[k];
        end
        if (!pre_ok) begin
            bad = $urandom_range(PREAMBLE_N - 1);
            inv[bad] = inv[bad] ^ 8'($urandom_range(255, 1));
        end
        for (int k = FIELD_FIRST; k <= XOR_LAST; k++) begin
            inv[k] = fields[8*(k-FIELD_FIRST) +: 8];
        end
        even_x = '0;
        odd_x  = '0;
        for (int k = 0; k <= XOR_LAST; k++) begin
            if (k % 2 == 1) begin
                odd_x = odd_x ^ inv[k];
            end else begin
                even_x = even_x ^ inv[k];
            end
        end
        inv[10] = checksum_of(even_x, odd_x);
        if (!sum_ok) begin
            inv[10] = inv[10] ^ 8'($urandom_range(255, 1));
        end
        inv[11] = 8'($urandom);
        for (int k = 0; k < len; k++) begin
            byte_q.push_back('{data: ~inv[k], start: (k == 0) ? first_start : 1'b0});
        end
        items_sent += len;
    endtask

    // Mostly well-formed frames; some corrupt, truncated, unflagged or padded
    task automatic queue_random_frame();
        int pad;
        if ($urandom_range(99) < 6) begin
            pad = $urandom_range(3, 1);
            repeat (pad) byte_q.push_back('{data: 8'($urandom), start: 1'b0});
        end
        queue_frame(56'({$urandom, $urandom}), $urandom_range(99) >= 4,
                    $urandom_range(99) >= 15, $urandom_range(99) >= 30,
                    ($urandom_range(99) < 7) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN);
    endtask

    // Wait until every byte is taken and every record has been popped
    task automatic drain();
        while (byte_q.size() != 0 || record_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int upto);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < upto) begin
            queue_random_frame();
        end
        drain();
    endtask

    // Stimulus sequence
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First frame without a start flag, fields at their maximum
        queue_frame(56'hFF_FF_FF_FF_FF_77_FF, 1'b0, 1'b1, 1'b1, FRAME_LEN);
        // Byte after a complete frame is ignored
        byte_q.push_back('{data: 8'h00, start: 1'b0});
        // Minimum temperature, low battery, zero fields
        queue_frame(56'h00_00_00_00_00_88_00, 1'b1, 1'b1, 1'b1, FRAME_LEN);
        drain();

        run_phase(0, 0, 250);

        // Receiver holds off while frames keep arriving, so the input backs up
        rx_hold = 400;
        repeat (10) queue_frame(56'({$urandom, $urandom}), 1'b1, 1'b1, 1'b1, FRAME_LEN);
        drain();

        run_phase(75, 0, 450);
        run_phase(0, 75, 700);
        run_phase(31, 31, 1050);

        recv_stall_pct = 0;
        send_idle_pct  = 0;
        repeat (10) @(posedge i_clk);

        $display("Run: %0d frame bytes pushed, %0d records checked", items_sent, records_checked);
        $display("Status mix: %0d valid, %0d preamble, %0d checksum; %0d stalled push cycles",
                 status_seen[STATUS_VALID], status_seen[STATUS_PREAMBLE],
                 status_seen[STATUS_CHECKSUM], stall_cycles);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
